// ===== rtl/core/fae_pkg.sv =====
`timescale 1ns / 1ps

package fae_pkg;

	// Sizing
	localparam int MAX_NAME_BYTES   = 16;
	localparam int MAX_BUFFER_BYTES = 256;
	localparam int POS_W            = 5;
	localparam int NAME_IDX_W       = 4;
	localparam int BSZ_W            = 9;
	localparam int CNT_W            = $clog2(MAX_BUFFER_BYTES);
	localparam int LIM_W            = (CNT_W + 1 > BSZ_W) ? CNT_W + 1 : BSZ_W;
	localparam int CFG_IDX_W        = 2;
	localparam int FIFO_DEPTH       = 4;
	localparam int FIFO_PTR_W       = $clog2(FIFO_DEPTH);

	// Characters with a meaning of their own
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NAME_LO  = 2'd0,
		CFG_NAME_HI  = 2'd1,
		CFG_NAME_LEN = 2'd2,
		CFG_BUF_SIZE = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_KEY   = 2'd0,
		MODE_VALUE = 2'd1,
		MODE_SKIP  = 2'd2,
		MODE_FOUND = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_PCT  = 2'd1,
		ESC_HEX  = 2'd2
	} esc_t;

	typedef struct packed {
		logic [15:0][7:0] name;
		logic [4:0]       key_len;
		logic [BSZ_W-1:0] dst_bytes;
	} cfg_t;

	// Up to three result bytes of one item
	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][7:0] b;
	} list_t;

	// One queue entry: all results of one item
	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][7:0] b;
		logic            has_char;
		logic            last;
		logic            found;
	} bundle_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_decode(logic [7:0] c);
		hex_t r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.ok  = 1'b1;
			r.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.ok  = 1'b1;
			r.val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.ok  = 1'b1;
			r.val = 4'(c - 8'h37);
		end
		return r;
	endfunction

	function automatic list_t list_push(list_t l, logic [7:0] x);
		list_t r;
		r = l;
		if (l.cnt != 2'd3) begin
			r.b[l.cnt] = x;
			r.cnt      = l.cnt + 2'd1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/fae_cfg.sv =====
`timescale 1ns / 1ps

module fae_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fae_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data,
	output fae_pkg::cfg_t                 cfg
);
	import fae_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg           = cfg_q;

	// Write one register per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{name: '0, key_len: '0, dst_bytes: BSZ_W'(256)};
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_NAME_LO:  cfg_q.name[7:0]  <= cfg_data;
				CFG_NAME_HI:  cfg_q.name[15:8] <= cfg_data;
				CFG_NAME_LEN: cfg_q.key_len    <= cfg_data[4:0];
				CFG_BUF_SIZE: cfg_q.dst_bytes  <= cfg_data[BSZ_W-1:0];
				default:      cfg_q            <= cfg_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/fae_front.sv =====
`timescale 1ns / 1ps

module fae_front (
	input  logic            clk,
	input  logic            arst_n,
	input  fae_pkg::cfg_t   cfg,
	input  logic [7:0]      char_in,
	input  logic            no_char,
	input  logic            end_of_string,
	input  logic            push,
	output logic            full,
	input  logic            fifo_full,
	output logic            fifo_wr,
	output fae_pkg::bundle_t fifo_data
);
	import fae_pkg::*;

	mode_t             mode_q, mode_n;
	logic [POS_W-1:0]  pos_q, pos_n;
	logic              match_q, match_n;
	esc_t              esc_q, esc_n;
	logic [7:0]        held_q, held_n;
	logic [CNT_W-1:0]  emit_q, emit_n;
	logic              started_q, started_n;

	logic              accept, has_byte;
	logic [POS_W-1:0]  len_eff;
	logic              key_done;
	logic [7:0]        name_b;

	list_t             vlist, list;
	esc_t              esc_v;
	logic [7:0]        held_v;
	logic              vend;
	logic              do_plain;
	hex_t              hx, hh;

	logic [LIM_W-1:0]  bs_w, room_w;
	logic [CNT_W-1:0]  limit, room;
	logic [1:0]        n_emit;
	logic              found_n;

	assign full     = fifo_full;
	assign accept   = push && !fifo_full;
	assign has_byte = !no_char;

	// Clamp name length and look up the next expected name byte
	assign len_eff  = (cfg.key_len > POS_W'(MAX_NAME_BYTES)) ?
	                  POS_W'(MAX_NAME_BYTES) : cfg.key_len;
	assign key_done = match_q && (pos_q == len_eff);
	assign name_b   = cfg.name[pos_q[NAME_IDX_W-1:0]];

	// Decode one value byte against the pending escape
	always_comb begin
		vlist    = '0;
		esc_v    = esc_q;
		held_v   = held_q;
		vend     = 1'b0;
		do_plain = 1'b0;
		hx       = hex_decode(char_in);
		hh       = hex_decode(held_q);
		unique case (esc_q)
			ESC_PCT: begin
				if (hx.ok) begin
					held_v = char_in;
					esc_v  = ESC_HEX;
				end else begin
					vlist    = list_push(vlist, CH_PCT);
					esc_v    = ESC_NONE;
					do_plain = 1'b1;
				end
			end
			ESC_HEX: begin
				if (hx.ok) begin
					vlist = list_push(vlist, {hh.val, hx.val});
					esc_v = ESC_NONE;
				end else begin
					vlist    = list_push(vlist, CH_PCT);
					vlist    = list_push(vlist, held_q);
					esc_v    = ESC_NONE;
					do_plain = 1'b1;
				end
			end
			default: do_plain = 1'b1;
		endcase
		if (do_plain) begin
			if (char_in == CH_AMP) begin
				vend = 1'b1;
			end else if (char_in == CH_PCT) begin
				esc_v = ESC_PCT;
			end else begin
				vlist = list_push(vlist, (char_in == CH_PLUS) ? CH_SPACE : char_in);
			end
		end
	end

	// Next parse state for an accepted item
	always_comb begin
		mode_n    = mode_q;
		pos_n     = pos_q;
		match_n   = match_q;
		esc_n     = esc_q;
		held_n    = held_q;
		started_n = started_q;
		if (has_byte) begin
			unique case (mode_q)
				MODE_KEY: begin
					started_n = 1'b1;
					if (char_in == CH_AMP) begin
						if (key_done) begin
							mode_n = MODE_FOUND;
						end else begin
							pos_n     = '0;
							match_n   = 1'b1;
							started_n = 1'b0;
						end
					end else if (char_in == CH_EQ) begin
						mode_n = key_done ? MODE_VALUE : MODE_SKIP;
					end else if (match_q && pos_q < len_eff && char_in == name_b) begin
						pos_n = pos_q + POS_W'(1);
					end else begin
						match_n = 1'b0;
					end
				end
				MODE_SKIP: begin
					if (char_in == CH_AMP) begin
						mode_n    = MODE_KEY;
						pos_n     = '0;
						match_n   = 1'b1;
						started_n = 1'b0;
					end
				end
				MODE_VALUE: begin
					esc_n  = esc_v;
					held_n = held_v;
					if (vend) begin
						mode_n = MODE_FOUND;
					end
				end
				default: mode_n = mode_q;
			endcase
		end
	end

	// Gather result bytes, flush a pending escape at the end, apply the limit
	always_comb begin
		list = '0;
		if (has_byte && mode_q == MODE_VALUE) begin
			list = vlist;
		end
		if (end_of_string && mode_n == MODE_VALUE) begin
			if (esc_n == ESC_PCT) begin
				list = list_push(list, CH_PCT);
			end else if (esc_n == ESC_HEX) begin
				list = list_push(list, CH_PCT);
				list = list_push(list, held_n);
			end
		end
		bs_w = LIM_W'(cfg.dst_bytes);
		if (bs_w == '0) begin
			limit = '0;
		end else if (bs_w > LIM_W'(MAX_BUFFER_BYTES)) begin
			limit = CNT_W'(MAX_BUFFER_BYTES - 1);
		end else begin
			limit = CNT_W'(bs_w - LIM_W'(1));
		end
		room   = limit - emit_q;
		room_w = LIM_W'(room);
		n_emit = (room_w < LIM_W'(list.cnt)) ? room_w[1:0] : list.cnt;
		emit_n = emit_q + CNT_W'(n_emit);
	end

	// Build the queue entry
	always_comb begin
		found_n = (mode_n == MODE_VALUE || mode_n == MODE_FOUND ||
		           (mode_n == MODE_KEY && started_n && match_n && pos_n == len_eff)) &&
		          (cfg.dst_bytes != '0);
		fifo_data          = '0;
		fifo_data.last     = end_of_string;
		fifo_data.found    = found_n;
		if (n_emit != 2'd0) begin
			fifo_data.cnt      = n_emit;
			fifo_data.b        = list.b;
			fifo_data.has_char = 1'b1;
		end else begin
			fifo_data.cnt      = 2'd1;
			fifo_data.has_char = 1'b0;
		end
		fifo_wr = accept && (n_emit != 2'd0 || end_of_string);
	end

	// Advance parse state; drop it back to reset at the end of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_KEY;
			pos_q     <= '0;
			match_q   <= 1'b1;
			esc_q     <= ESC_NONE;
			held_q    <= '0;
			emit_q    <= '0;
			started_q <= 1'b0;
		end else if (accept) begin
			if (end_of_string) begin
				mode_q    <= MODE_KEY;
				pos_q     <= '0;
				match_q   <= 1'b1;
				esc_q     <= ESC_NONE;
				held_q    <= '0;
				emit_q    <= '0;
				started_q <= 1'b0;
			end else begin
				mode_q    <= mode_n;
				pos_q     <= pos_n;
				match_q   <= match_n;
				esc_q     <= esc_n;
				held_q    <= held_n;
				emit_q    <= emit_n;
				started_q <= started_n;
			end
		end
	end

`ifndef SYNTHESIS
	a_esc_in_value: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q != ESC_NONE |-> mode_q == MODE_VALUE)
		else $error("escape pending outside value");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_NAME_BYTES))
		else $error("key position beyond name");
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_string |=> mode_q == MODE_KEY && pos_q == '0 && emit_q == '0)
		else $error("parse state not cleared after string");
`endif

endmodule

// ===== rtl/core/fae_fifo.sv =====
`timescale 1ns / 1ps

module fae_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  fae_pkg::bundle_t wdata,
	output logic             full,
	input  logic             rd,
	output fae_pkg::bundle_t rdata,
	output logic             empty
);
	import fae_pkg::*;

	bundle_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wptr_q, rptr_q;
	logic [FIFO_PTR_W:0]    count_q;
	logic                   do_wr, do_rd;

	assign full  = (count_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 :
				          wptr_q + FIFO_PTR_W'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 :
				          rptr_q + FIFO_PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (FIFO_PTR_W + 1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (FIFO_PTR_W + 1)'(1);
			end
		end
	end

endmodule

// ===== rtl/core/fae_back.sv =====
`timescale 1ns / 1ps

module fae_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fifo_empty,
	input  fae_pkg::bundle_t fifo_data,
	output logic             fifo_rd,
	output logic             empty,
	input  logic             pop,
	output logic [7:0]       decoded_char,
	output logic             has_char,
	output logic             found,
	output logic             done_res
);
	import fae_pkg::*;

	bundle_t    cur_q;
	logic       valid_q;
	logic [1:0] idx_q;
	logic       last_beat, adv;

	assign last_beat = (idx_q == cur_q.cnt - 2'd1);
	assign adv       = !valid_q || (pop && last_beat);
	assign fifo_rd   = adv && !fifo_empty;

	// Present the current result of the held entry
	assign empty        = !valid_q;
	assign has_char     = cur_q.has_char;
	assign decoded_char = cur_q.has_char ? cur_q.b[idx_q] : 8'h00;
	assign done_res     = cur_q.last && last_beat;
	assign found        = cur_q.last && last_beat && cur_q.found;

	// Load the next entry when none is held, or once the last beat of this one goes out
	always_ff @(posedge clk) begin
		if (fifo_rd) begin
			cur_q <= fifo_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (adv) begin
				valid_q <= !fifo_empty;
			end
			if (fifo_rd) begin
				idx_q <= '0;
			end else if (pop && valid_q && !last_beat) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> idx_q < cur_q.cnt)
		else $error("result index beyond entry");
	a_rd_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_rd |-> !fifo_empty)
		else $error("read from empty queue");
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !pop |=> valid_q && $stable(idx_q))
		else $error("result moved while stalled");
`endif

endmodule

// ===== rtl/core/form_argument_extract_decode_top.sv =====
`timescale 1ns / 1ps

// Form argument extractor with percent decoding.
// Input side is a queue push port: present char_in, no_char and end_of_string
// with push; a beat is taken on a clock edge with push high and full low.
// Results come out of a queue pop port: while empty is low the oldest result
// sits on decoded_char, has_char, found and done_res; pop takes it.
// Configuration is a valid/ready write channel (cfg_index, cfg_data), always
// ready; write it only while no string is in flight.
// The front parses one byte per cycle while full is low, so input runs at one
// beat per cycle. Each byte yields zero to three results, kept as one entry in
// a four-deep queue; the back hands them out one per cycle while pop is high,
// so the pop side limits rate when escapes flush several bytes at once. The
// back registers each entry before it shows. If pop stays low the queue fills
// and full rises; nothing is dropped.
// Reset clears parse state, empties the queue, and sets name_length to 0 and
// buffer_size to 256.
module form_argument_extract_decode_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    char_in,
	input  logic                          no_char,
	input  logic                          end_of_string,
	output logic                          empty,
	input  logic                          pop,
	output logic [7:0]                    decoded_char,
	output logic                          has_char,
	output logic                          found,
	output logic                          done_res,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fae_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data
);
	import fae_pkg::*;

	cfg_t    cfg;
	logic    fifo_full, fifo_wr, fifo_rd, fifo_empty;
	bundle_t fifo_wdata, fifo_rdata;

	fae_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fae_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.char_in       (char_in),
		.no_char       (no_char),
		.end_of_string (end_of_string),
		.push          (push),
		.full          (full),
		.fifo_full     (fifo_full),
		.fifo_wr       (fifo_wr),
		.fifo_data     (fifo_wdata)
	);

	fae_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fifo_wr),
		.wdata  (fifo_wdata),
		.full   (fifo_full),
		.rd     (fifo_rd),
		.rdata  (fifo_rdata),
		.empty  (fifo_empty)
	);

	fae_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fifo_empty   (fifo_empty),
		.fifo_data    (fifo_rdata),
		.fifo_rd      (fifo_rd),
		.empty        (empty),
		.pop          (pop),
		.decoded_char (decoded_char),
		.has_char     (has_char),
		.found        (found),
		.done_res     (done_res)
	);

endmodule

// ===== bench/form_argument_extract_decode_top_tb.sv =====
`timescale 1ns / 1ps

module form_argument_extract_decode_top_tb;
	import fae_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic       no_ch;
		logic       last;
	} form_beat_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       has;
		logic       fnd;
		logic       done;
	} arg_out_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] char_in = '0;
	logic       no_char = 1'b0;
	logic       end_of_string = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] decoded_char;
	logic       has_char;
	logic       found;
	logic       done_res;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	cfg_idx_t   cfg_index = CFG_NAME_LO;
	logic [63:0] cfg_data = '0;

	// Register copy and scan state of the argument decoder
	logic [63:0] arg_name_lo = '0;
	logic [63:0] arg_name_hi = '0;
	logic [4:0]  arg_name_len = '0;
	logic [8:0]  arg_buf_size = 9'd256;
	mode_t       scan_mode = MODE_KEY;
	int unsigned key_pos = 0;
	bit          key_ok = 1'b1;
	esc_t        esc_stage = ESC_NONE;
	logic [7:0]  esc_first = '0;
	int unsigned value_count = 0;
	bit          pair_seen = 1'b0;

	form_beat_t  beat_q[$];
	arg_out_t    decoded_q[$];
	arg_out_t    step_q[$];

	// Stimulus building
	logic [7:0]  form_buf[$];
	logic [7:0]  form_name[16];
	int unsigned form_span = 0;
	int unsigned form_items = 0;
	bit          quiet_phase = 1'b0;

	int unsigned mismatches = 0;
	int unsigned send_gap = 0;
	bit          send_hold = 1'b0;
	int unsigned take_stall = 0;

	form_argument_extract_decode_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.char_in       (char_in),
		.no_char       (no_char),
		.end_of_string (end_of_string),
		.empty         (empty),
		.pop           (pop),
		.decoded_char  (decoded_char),
		.has_char      (has_char),
		.found         (found),
		.done_res      (done_res),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("form_argument_extract_decode_top verification failed");
		$finish;
	end

	// ---------------------------------------------------------------- prediction

	function automatic int unsigned name_span();
		return (arg_name_len > MAX_NAME_BYTES) ? MAX_NAME_BYTES : int'(arg_name_len);
	endfunction

	function automatic int unsigned value_room();
		int unsigned bsz;
		bsz = (arg_buf_size > MAX_BUFFER_BYTES) ? MAX_BUFFER_BYTES : int'(arg_buf_size);
		return (bsz == 0) ? 0 : bsz - 1;
	endfunction

	function automatic logic [7:0] name_char(int unsigned pos);
		return (pos < 8) ? arg_name_lo[8*pos +: 8] : arg_name_hi[8*(pos-8) +: 8];
	endfunction

	function automatic bit is_hex(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] hex_nibble(logic [7:0] c);
		if (c <= "9")
			return 4'(c - "0");
		if (c <= "F")
			return 4'(c - "A" + 8'd10);
		return 4'(c - "a" + 8'd10);
	endfunction

	// Emit one value byte unless the buffer or the per-beat slots are used up
	function automatic void put_byte(logic [7:0] c);
		if (value_count >= value_room() || step_q.size() >= 3)
			return;
		value_count++;
		step_q.push_back('{ch: c, has: 1'b1, fnd: 1'b0, done: 1'b0});
	endfunction

	function automatic void flush_escape();
		if (esc_stage == ESC_PCT) begin
			put_byte(CH_PCT);
		end else if (esc_stage == ESC_HEX) begin
			put_byte(CH_PCT);
			put_byte(esc_first);
		end
		esc_stage = ESC_NONE;
	endfunction

	// Decode one value byte; return 1 when it closes the value
	function automatic bit value_ends(logic [7:0] c);
		if (esc_stage == ESC_PCT) begin
			if (is_hex(c)) begin
				esc_first = c;
				esc_stage = ESC_HEX;
				return 1'b0;
			end
			put_byte(CH_PCT);
			esc_stage = ESC_NONE;
		end else if (esc_stage == ESC_HEX) begin
			if (is_hex(c)) begin
				put_byte({hex_nibble(esc_first), hex_nibble(c)});
				esc_stage = ESC_NONE;
				return 1'b0;
			end
			put_byte(CH_PCT);
			put_byte(esc_first);
			esc_stage = ESC_NONE;
		end
		// a broken escape falls through: handle this byte afresh
		if (c == CH_AMP)
			return 1'b1;
		if (c == CH_PCT) begin
			esc_stage = ESC_PCT;
			return 1'b0;
		end
		put_byte((c == CH_PLUS) ? CH_SPACE : c);
		return 1'b0;
	endfunction

	function automatic bit key_matched();
		return key_ok && key_pos == name_span();
	endfunction

	function automatic void restart_key();
		key_pos = 0;
		key_ok = 1'b1;
		pair_seen = 1'b0;
	endfunction

	function automatic void take_key_byte(logic [7:0] c);
		pair_seen = 1'b1;
		if (c == CH_AMP) begin
			if (key_matched())
				scan_mode = MODE_FOUND;
			else
				restart_key();
		end else if (c == CH_EQ) begin
			scan_mode = key_matched() ? MODE_VALUE : MODE_SKIP;
		end else if (key_ok && key_pos < name_span() && c == name_char(key_pos)) begin
			key_pos++;
		end else begin
			key_ok = 1'b0;
		end
	endfunction

	// Work out the results of one accepted beat and queue them
	function automatic void predict_beat(logic [7:0] c, logic no_ch, logic last);
		bit hit;
		step_q.delete();
		if (!no_ch) begin
			case (scan_mode)
			MODE_KEY: begin
				take_key_byte(c);
			end
			MODE_SKIP: begin
				if (c == CH_AMP) begin
					scan_mode = MODE_KEY;
					restart_key();
				end
			end
			MODE_VALUE: begin
				if (value_ends(c)) begin
					flush_escape();
					scan_mode = MODE_FOUND;
				end
			end
			default: begin
			end
			endcase
		end
		if (last) begin
			if (scan_mode == MODE_VALUE)
				flush_escape();
			hit = scan_mode == MODE_VALUE || scan_mode == MODE_FOUND ||
				(scan_mode == MODE_KEY && pair_seen && key_matched());
			if (arg_buf_size == 0)
				hit = 1'b0;
			if (step_q.size() == 0)
				step_q.push_back('0);
			step_q[step_q.size()-1].fnd = hit;
			step_q[step_q.size()-1].done = 1'b1;
			scan_mode = MODE_KEY;
			esc_stage = ESC_NONE;
			esc_first = '0;
			value_count = 0;
			restart_key();
		end
		foreach (step_q[i])
			decoded_q.push_back(step_q[i]);
	endfunction

	// Track register writes
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
			CFG_NAME_LO: begin
				arg_name_lo <= cfg_data;
			end
			CFG_NAME_HI: begin
				arg_name_hi <= cfg_data;
			end
			CFG_NAME_LEN: begin
				arg_name_len <= cfg_data[4:0];
			end
			CFG_BUF_SIZE: begin
				arg_buf_size <= cfg_data[8:0];
			end
			default: begin
			end
			endcase
		end
	end

	// ---------------------------------------------------------------- handshakes

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet_phase)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned pick_stall();
		int unsigned r;
		if (quiet_phase)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Drive input beats from the pending queue
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				predict_beat(char_in, no_char, end_of_string);
				void'(beat_q.pop_front());
				send_gap = pick_gap();
				if (!quiet_phase && $urandom_range(0, 79) == 0)
					send_hold = 1'b1;
			end
			// release a hold-off once every expected result has drained
			if (send_hold && decoded_q.size() == 0)
				send_hold = 1'b0;
			// a stalled beat stays on the ports unchanged
			if (!(push && full)) begin
				if (send_gap == 0 && !send_hold && beat_q.size() != 0) begin
					push          <= 1'b1;
					char_in       <= beat_q[0].ch;
					no_char       <= beat_q[0].no_ch;
					end_of_string <= beat_q[0].last;
				end else begin
					push <= 1'b0;
					if (send_gap != 0)
						send_gap--;
				end
			end
		end
	end

	function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// Take result beats and compare them with the oldest expectation
	always @(posedge clk) begin : result_check
		arg_out_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (decoded_q.size() == 0) begin
					$display("%0t ns: unexpected result: expected none, actual %0h/%0b/%0b/%0b",
						$time, decoded_char, has_char, found, done_res);
					mismatches++;
				end else begin
					want = decoded_q.pop_front();
					check_field("decoded_char", want.ch, decoded_char);
					check_field("has_char", 8'(want.has), 8'(has_char));
					check_field("found", 8'(want.fnd), 8'(found));
					check_field("done_res", 8'(want.done), 8'(done_res));
				end
			end
			if (take_stall != 0) begin
				pop <= 1'b0;
				take_stall--;
			end else begin
				pop <= 1'b1;
				take_stall = pick_stall();
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_config(logic [127:0] nm, logic [4:0] len, logic [8:0] bsz);
		logic [63:0] junk;
		for (int i = 0; i < 16; i++)
			form_name[i] = nm[8*i +: 8];
		form_span = (len > MAX_NAME_BYTES) ? MAX_NAME_BYTES : int'(len);
		junk = {$urandom, $urandom};
		write_reg(CFG_NAME_LO, nm[63:0]);
		write_reg(CFG_NAME_HI, nm[127:64]);
		write_reg(CFG_NAME_LEN, {junk[63:5], len});
		write_reg(CFG_BUF_SIZE, {junk[63:9], bsz});
		@(negedge clk);
	endtask

	// Wait until the block is drained, then let its pipeline settle
	task automatic wait_idle();
		@(negedge clk);
		while (beat_q.size() != 0 || push || decoded_q.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic add_beat(logic [7:0] c, logic no_ch, logic last);
		beat_q.push_back('{ch: c, no_ch: no_ch, last: last});
		if (!no_ch || last)
			form_items++;
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++)
			form_buf.push_back(s[i]);
	endtask

	// Queue the built string; optionally close it with an empty final beat
	task automatic send_form(bit sep_end);
		if (form_buf.size() == 0) begin
			add_beat(8'($urandom), 1'b1, 1'b1);
		end else begin
			foreach (form_buf[i]) begin
				if ($urandom_range(0, 29) == 0)
					add_beat(8'($urandom), 1'b1, 1'b0);
				add_beat(form_buf[i], 1'b0, !sep_end && i == form_buf.size() - 1);
			end
			if (sep_end)
				add_beat(8'($urandom), 1'b1, 1'b1);
		end
		form_buf.delete();
	endtask

	function automatic logic [7:0] name_letter();
		case ($urandom_range(0, 11))
		0, 1, 2, 3: return "a";
		4, 5:       return "b";
		6:          return CH_PCT;
		7:          return CH_PLUS;
		8:          return "0";
		9:          return "F";
		10:         return 8'($urandom);
		default:    return CH_EQ;
		endcase
	endfunction

	function automatic logic [7:0] value_char();
		string digits;
		digits = "0123456789abcdefABCDEF";
		case ($urandom_range(0, 15))
		0, 1:          return CH_PLUS;
		2, 3:          return CH_PCT;
		4, 5, 6, 7:    return digits[$urandom_range(0, 21)];
		8:             return 8'("g" + $urandom_range(0, 19));
		9:             return CH_EQ;
		10:            return 8'($urandom);
		default:       return 8'($urandom_range(8'h20, 8'h7E));
		endcase
	endfunction

	// Key that matches the name, nearly matches it, or is unrelated
	task automatic add_key();
		int unsigned kind;
		int unsigned n;
		kind = $urandom_range(0, 9);
		n = (kind == 5 && form_span != 0) ? form_span - 1 : form_span;
		if (kind < 8) begin
			for (int i = 0; i < n; i++)
				form_buf.push_back(form_name[i]);
			if (kind == 6)
				form_buf.push_back(name_letter());
			if (kind == 7 && n != 0)
				form_buf[form_buf.size() - 1 - $urandom_range(0, n - 1)] ^= 8'(1 << $urandom_range(0, 7));
		end else begin
			repeat ($urandom_range(0, 4)) form_buf.push_back(name_letter());
		end
	endtask

	task automatic random_form();
		int unsigned kind;
		kind = $urandom_range(0, 19);
		if (kind == 1) begin
			// noise
			repeat ($urandom_range(1, 8)) form_buf.push_back(8'($urandom));
		end else if (kind != 0) begin
			if (kind == 2)
				form_buf.push_back(CH_AMP);
			for (int p = 0; p < $urandom_range(1, 3); p++) begin
				if (p != 0)
					form_buf.push_back(CH_AMP);
				add_key();
				if ($urandom_range(0, 6) != 0) begin
					form_buf.push_back(CH_EQ);
					repeat ($urandom_range(0, 7)) form_buf.push_back(value_char());
				end
			end
			if (kind == 3)
				form_buf.push_back(CH_AMP);
		end
		send_form($urandom_range(0, 4) == 0);
	endtask

	function automatic logic [127:0] random_name();
		logic [127:0] nm;
		nm = {$urandom, $urandom, $urandom, $urandom};
		for (int i = 0; i < 16; i++)
			if ($urandom_range(0, 3) != 0)
				nm[8*i +: 8] = name_letter();
		return nm;
	endfunction

	initial begin
		logic [127:0] nm;
		logic [4:0]   len;
		logic [8:0]   bsz;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed strings against the name "key"
		nm = {$urandom, $urandom, $urandom, $urandom};
		nm[23:0] = {"y", "e", "k"};
		load_config(nm, 5'd3, 9'd256);
		send_form(1'b0);
		put_text("key=%4a%");
		send_form(1'b0);
		put_text("ab&key");
		send_form(1'b0);
		put_text("key=+%g");
		form_buf.push_back(8'h00);
		form_buf.push_back(8'hFF);
		send_form(1'b1);
		wait_idle();

		// Random phases, each with its own register setting
		for (int ph = 1; ph <= 8; ph++) begin
			nm = random_name();
			quiet_phase = 1'b0;
			case (ph)
			1: begin
				nm[23:0] = {"y", "e", "k"};
				len = 5'd3;
				bsz = 9'd0;
			end
			2: begin
				len = 5'd31;
				bsz = 9'd511;
				quiet_phase = 1'b1;
			end
			3: begin
				len = 5'd0;
				bsz = 9'd2;
			end
			4: begin
				len = 5'd16;
				bsz = 9'd1;
			end
			5: begin
				len = 5'($urandom_range(1, 4));
				bsz = 9'd5;
				quiet_phase = 1'b1;
			end
			6: begin
				len = 5'd1;
				bsz = 9'($urandom_range(0, 511));
			end
			7: begin
				len = 5'($urandom_range(0, 31));
				bsz = 9'd256;
			end
			default: begin
				len = 5'd2;
				bsz = 9'd20;
			end
			endcase
			load_config(nm, len, bsz);
			form_items = 0;
			if (ph == 2) begin
				// long value runs into the clamped buffer limit
				for (int i = 0; i < form_span; i++)
					form_buf.push_back(form_name[i]);
				form_buf.push_back(CH_EQ);
				repeat (262) form_buf.push_back(8'("a" + $urandom_range(0, 25)));
				send_form(1'b0);
			end
			while (form_items < 10)
				random_form();
			wait_idle();
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("form_argument_extract_decode_top verification clean");
		else
			$display("form_argument_extract_decode_top verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/fae_pkg.sv
rtl/core/fae_cfg.sv
rtl/core/fae_front.sv
rtl/core/fae_fifo.sv
rtl/core/fae_back.sv
rtl/core/form_argument_extract_decode_top.sv
bench/form_argument_extract_decode_top_tb.sv
